### rtl/vlr3d_pkg.sv
// ----------------------------------------------------------------------------
// vlr3d_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the 3D voxel line rasterizer.
// ----------------------------------------------------------------------------
package vlr3d_pkg;

  // Result and configuration field widths
  localparam int unsigned ADDR_W     = 18;
  localparam int unsigned VAL_W      = 8;
  localparam int unsigned ROW_W      = 7;
  localparam int unsigned PLANE_W    = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_STRIDE = 1'b1;

  // Register reset values
  localparam logic [ROW_W-1:0]   ROW_STRIDE_RST   = 7'd8;
  localparam logic [PLANE_W-1:0] PLANE_STRIDE_RST = 13'd64;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture a new line request
    logic init;  // set up cursor, error terms and step deltas
    logic emit;  // move cursor into output register and advance
  } vlr3d_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;  // cursor sits on the second endpoint
  } vlr3d_status_t;

endpackage

### rtl/voxel_line_rasterizer_3d_core.sv
// ----------------------------------------------------------------------------
// voxel_line_rasterizer_3d_core
// 3D Bresenham line walker: one line request in, one frame-buffer write per
// voxel out, address z*plane_stride + y*row_stride + x modulo 2^18.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid_i/in_stall_o  | start_{x,y,z}, end_{x,y,z},
//          |           |                      | brightness
//  out     | output    | out_valid_o/out_stall_i| voxel_address, write_value,
//          |           |                      | last_point
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index (0 row, 1 plane),
//          |           |                      | cfg_data
//
//  A line whose dominant axis length is L yields L+1 items, one per cycle
//  while the output is not stalled; after accept, a request passes through
//  setup before the single cursor stepper issues its items.
//  Reset clears the controller and restores strides to 8 and 64.
//  A stalled output freezes the stepper; the next request is taken as soon
//  as the last item of the current one sits in the output register.
// ----------------------------------------------------------------------------
module voxel_line_rasterizer_3d_core import vlr3d_pkg::*; #(
  parameter int unsigned COORD_BITS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] start_z_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic [COORD_BITS-1:0] end_z_i,
  input  logic [VAL_W-1:0]      brightness_i,
  // voxel write channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ADDR_W-1:0]     voxel_address_o,
  output logic [VAL_W-1:0]      write_value_o,
  output logic                  last_point_o,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  vlr3d_cmd_t    cmd;
  vlr3d_status_t status;

  // Strides are to change only between requests; the block does not enforce this and cfg_ready_o is tied high.
  assign cfg_ready_o = 1'b1;

  // Sequencer: capture, setup, then one step per free output slot
  vlr3d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Cursor, error terms, strides and output register
  vlr3d_dp #(
    .CoordBits (COORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .start_z_i       (start_z_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .end_z_i         (end_z_i),
    .brightness_i    (brightness_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .voxel_address_o (voxel_address_o),
    .write_value_o   (write_value_o),
    .last_point_o    (last_point_o)
  );

endmodule

### rtl/vlr3d_ctrl.sv
// ----------------------------------------------------------------------------
// vlr3d_ctrl
// Sequencer for one line request: capture, set up, then step one voxel per
// free output slot until the second endpoint has been issued.
// ----------------------------------------------------------------------------
module vlr3d_ctrl import vlr3d_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  vlr3d_status_t status_i,
  output vlr3d_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_RUN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o.load = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.init = (state_q == ST_INIT);
    cmd_o.emit = (state_q == ST_RUN) && out_free;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (status_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_accept_to_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_INIT)
    else $error("accepted request did not enter setup");

  a_init_to_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INIT |=> state_q == ST_RUN && !cmd_o.load)
    else $error("setup did not enter run");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_o)
    else $error("issued voxel not presented");

  a_last_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit && status_i.last |=> state_q == ST_IDLE)
    else $error("run continued past second endpoint");
`endif

endmodule

### rtl/vlr3d_dp.sv
// ----------------------------------------------------------------------------
// vlr3d_dp
// Stepping datapath: stride registers, request capture, cursor address,
// two minor-axis error terms, step counter and the output register.
// ----------------------------------------------------------------------------
module vlr3d_dp import vlr3d_pkg::*; #(
  parameter int unsigned CoordBits = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [CoordBits-1:0]  start_x_i,
  input  logic [CoordBits-1:0]  start_y_i,
  input  logic [CoordBits-1:0]  start_z_i,
  input  logic [CoordBits-1:0]  end_x_i,
  input  logic [CoordBits-1:0]  end_y_i,
  input  logic [CoordBits-1:0]  end_z_i,
  input  logic [VAL_W-1:0]      brightness_i,
  input  vlr3d_cmd_t            cmd_i,
  output vlr3d_status_t         status_o,
  output logic [ADDR_W-1:0]     voxel_address_o,
  output logic [VAL_W-1:0]      write_value_o,
  output logic                  last_point_o
);

  localparam int unsigned LW  = CoordBits + 1;  // twice a length
  localparam int unsigned EW  = CoordBits + 3;  // signed error term
  localparam int unsigned ZPW = CoordBits + PLANE_W;
  localparam int unsigned YPW = CoordBits + ROW_W;

  // Stride registers
  logic [ROW_W-1:0]   row_stride_q;
  logic [PLANE_W-1:0] plane_stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_stride_q   <= ROW_STRIDE_RST;
      plane_stride_q <= PLANE_STRIDE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROW_STRIDE:   row_stride_q   <= cfg_data_i[ROW_W-1:0];
        REG_PLANE_STRIDE: plane_stride_q <= cfg_data_i[PLANE_W-1:0];
        default: ;
      endcase
    end
  end

  // Request capture: lengths, directions, partial address products
  logic                 neg_x_d, neg_y_d, neg_z_d;
  logic [CoordBits-1:0] len_x_d, len_y_d, len_z_d;
  logic                 neg_x_q, neg_y_q, neg_z_q;
  logic [CoordBits-1:0] len_x_q, len_y_q, len_z_q;
  logic [ZPW-1:0]       zprod_q;
  logic [YPW-1:0]       yprod_q;
  logic [CoordBits-1:0] x_q;
  logic [VAL_W-1:0]     val_q;

  always_comb begin
    neg_x_d = end_x_i < start_x_i;
    neg_y_d = end_y_i < start_y_i;
    neg_z_d = end_z_i < start_z_i;
    len_x_d = neg_x_d ? start_x_i - end_x_i : end_x_i - start_x_i;
    len_y_d = neg_y_d ? start_y_i - end_y_i : end_y_i - start_y_i;
    len_z_d = neg_z_d ? start_z_i - end_z_i : end_z_i - start_z_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_x_q <= neg_x_d;
      neg_y_q <= neg_y_d;
      neg_z_q <= neg_z_d;
      len_x_q <= len_x_d;
      len_y_q <= len_y_d;
      len_z_q <= len_z_d;
      zprod_q <= ZPW'(start_z_i) * ZPW'(plane_stride_q);
      yprod_q <= YPW'(start_y_i) * YPW'(row_stride_q);
      x_q     <= start_x_i;
      val_q   <= brightness_i;
    end
  end

  // Setup: dominant axis, signed address steps, initial error terms
  logic [ADDR_W-1:0]    dx, dy, dz;
  logic [ADDR_W-1:0]    d_maj_d, d_m1_d, d_m2_d;
  logic [CoordBits-1:0] n_d, lm1_d, lm2_d;
  logic [ADDR_W-1:0]    addr_init;

  always_comb begin
    dx = neg_x_q ? ADDR_W'(0) - ADDR_W'(1) : ADDR_W'(1);
    dy = neg_y_q ? ADDR_W'(0) - ADDR_W'(row_stride_q) : ADDR_W'(row_stride_q);
    dz = neg_z_q ? ADDR_W'(0) - ADDR_W'(plane_stride_q) : ADDR_W'(plane_stride_q);
    if (len_x_q >= len_y_q && len_x_q >= len_z_q) begin
      n_d = len_x_q; lm1_d = len_y_q; lm2_d = len_z_q;
      d_maj_d = dx;  d_m1_d = dy;     d_m2_d = dz;
    end else if (len_y_q >= len_z_q) begin
      n_d = len_y_q; lm1_d = len_x_q; lm2_d = len_z_q;
      d_maj_d = dy;  d_m1_d = dx;     d_m2_d = dz;
    end else begin
      n_d = len_z_q; lm1_d = len_y_q; lm2_d = len_x_q;
      d_maj_d = dz;  d_m1_d = dy;     d_m2_d = dx;
    end
    addr_init = ADDR_W'(zprod_q) + ADDR_W'(yprod_q) + ADDR_W'(x_q);
  end

  // Cursor
  logic [ADDR_W-1:0]    addr_q, d_maj_q, d_m1_q, d_m2_q;
  logic signed [EW-1:0] e1_q, e2_q;
  logic [LW-1:0]        two_lm1_q, two_lm2_q, two_n_q;
  logic [CoordBits-1:0] cnt_q;
  logic                 step1, step2;
  logic [ADDR_W-1:0]    addr_next;
  logic signed [EW-1:0] e1_next, e2_next;

  always_comb begin
    step1     = !e1_q[EW-1] && (e1_q != '0);
    step2     = !e2_q[EW-1] && (e2_q != '0);
    addr_next = addr_q + d_maj_q + (step1 ? d_m1_q : '0) + (step2 ? d_m2_q : '0);
    e1_next   = e1_q - (step1 ? $signed(EW'(two_n_q)) : '0) + $signed(EW'(two_lm1_q));
    e2_next   = e2_q - (step2 ? $signed(EW'(two_n_q)) : '0) + $signed(EW'(two_lm2_q));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      addr_q    <= addr_init;
      d_maj_q   <= d_maj_d;
      d_m1_q    <= d_m1_d;
      d_m2_q    <= d_m2_d;
      two_lm1_q <= {lm1_d, 1'b0};
      two_lm2_q <= {lm2_d, 1'b0};
      two_n_q   <= {n_d, 1'b0};
      e1_q      <= $signed(EW'({lm1_d, 1'b0})) - $signed(EW'(n_d));
      e2_q      <= $signed(EW'({lm2_d, 1'b0})) - $signed(EW'(n_d));
    end else if (cmd_i.emit) begin
      addr_q <= addr_next;
      e1_q   <= e1_next;
      e2_q   <= e2_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.init) begin
      cnt_q <= n_d;
    end else if (cmd_i.emit && !status_o.last) begin
      cnt_q <= cnt_q - CoordBits'(1);
    end
  end

  assign status_o.last = (cnt_q == '0);

  // Output register: loads only when the controller finds the slot free
  logic [ADDR_W-1:0] out_addr_q;
  logic [VAL_W-1:0]  out_val_q;
  logic              out_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_addr_q <= addr_q;
      out_val_q  <= val_q;
      out_last_q <= status_o.last;
    end
  end

  assign voxel_address_o = out_addr_q;
  assign write_value_o   = out_val_q;
  assign last_point_o    = out_last_q;

`ifndef ASSERT_OFF
  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && !status_o.last |=> cnt_q == $past(cnt_q) - CoordBits'(1))
    else $error("step counter did not decrement");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_last_q == ($past(cnt_q) == '0))
    else $error("last flag does not match step counter");

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_i.load, cmd_i.init, cmd_i.emit}) <= 1)
    else $error("conflicting datapath commands");
`endif

endmodule
